/* rtl/scs_pkg.sv */
package scs_pkg;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 20;
  localparam int RPM_W    = 16;
  localparam int PCT_W    = 8;
  localparam int FLAGS_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PERIOD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LAUNCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REARM  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 2'd2;

  // Accepted period window in microseconds.
  localparam logic [TIME_W-1:0] PERIOD_MIN_US = 32'd1000;
  localparam logic [TIME_W-1:0] PERIOD_MAX_US = 32'd1000000;

  // Divider for rpm = 60000000 / period.
  localparam int DIV_NUM_W = 26;
  localparam int DIV_STEPS = 26;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR = 26'd60000000;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] MIN_DELAY_RST = 32'd1000000;
  localparam logic [PCT_W-1:0]  WARNING_RST   = 8'd20;
  localparam logic [PCT_W-1:0]  CRITICAL_RST  = 8'd10;

  // Status flag bit positions.
  localparam int FLAG_CRITICAL_BIT = 0;
  localparam int FLAG_ACTIVE_BIT   = 2;
  localparam int FLAG_WARNING_BIT  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } scs_state_t;

endpackage

/* rtl/scs_div.sv */
module scs_div
  import scs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [RPM_W-1:0]    quotient
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  divisor_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 ge;

  // One restoring step per cycle: the numerator shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    trial   = {rem_r, num_r[DIV_NUM_W-1]};
    diff    = trial - {1'b0, divisor_r};
    ge      = (trial >= {1'b0, divisor_r});
    rem_nxt = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    num_nxt = {num_r[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r     <= RPM_NUMERATOR;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r[RPM_W-1:0];

endmodule

/* rtl/spin_capture_session_core.sv */
// Spin-measurement session engine. Each input beat is one event (period,
// launch, finish, abort, tick or re-arm) and yields exactly one result beat
// with the battery status flags, the session peak rpm, an optional profile
// write and an optional commit. A period inside 1000..1000000 us that the
// session may take goes through a radix-2 divider, which works out
// rpm = 60000000 / period, one quotient bit per cycle, in state ST_DIV; its
// result is loaded in ST_DONE once the result register is free; the next
// beat is taken once back in ST_IDLE. Every other beat goes from ST_IDLE
// straight to ST_DONE and has its result loaded there the same way. One event
// is worked on at a time and in_tready is low meanwhile; the result register
// lets the next event in while a result still waits for out_tready.
// Configuration writes are always taken and should be made only while the
// block is idle.
module spin_capture_session_core
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, from bit 0: period[31:0], event_time_us[31:0],
  // record_flag, battery_percent[7:0], zero padding.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser, from bit 0: command[2:0].
  input  logic [CMD_W-1:0]      in_tuser,
  // out_tdata, from bit 0: flags[4:0], peak_rpm[15:0], profile_write,
  // profile_period[19:0], commit, commit_rpm[15:0], zero padding.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data
);

  scs_state_t state_r, state_nxt;

  // Input field views.
  logic [TIME_W-1:0] in_period;
  logic [TIME_W-1:0] in_evt;
  logic              in_rec;
  logic [PCT_W-1:0]  in_batt;

  assign in_period = in_tdata[TIME_W-1:0];
  assign in_evt    = in_tdata[2*TIME_W-1:TIME_W];
  assign in_rec    = in_tdata[2*TIME_W];
  assign in_batt   = in_tdata[2*TIME_W+PCT_W:2*TIME_W+1];

  // Latched event.
  logic [CMD_W-1:0]    cmd_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TIME_W-1:0]   evt_r;
  logic                rec_r;
  logic [PCT_W-1:0]    batt_r;
  logic                per_ok_r;

  // Session state.
  logic              started_r, started_nxt;
  logic              launched_r, launched_nxt;
  logic              pending_r, pending_nxt;
  logic              blocked_r, blocked_nxt;
  logic [TIME_W-1:0] start_time_r, start_time_nxt;
  logic [RPM_W-1:0]  best_rpm_r, best_rpm_nxt;

  // Configuration.
  logic [TIME_W-1:0] min_delay_r;
  logic [PCT_W-1:0]  warn_r;
  logic [PCT_W-1:0]  crit_r;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 accept;
  logic                 per_ok_in;
  logic                 div_start;
  logic                 div_done;
  logic [RPM_W-1:0]     div_quo;
  logic                 out_free;
  logic                 apply;
  logic [TIME_W-1:0]    elapsed;
  logic                 pw;
  logic [PERIOD_W-1:0]  pp;
  logic                 cm;
  logic [RPM_W-1:0]     crpm;
  logic [FLAGS_W-1:0]   flags;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign per_ok_in = (in_tuser == CMD_PERIOD) && !blocked_r && !pending_r &&
                     (in_period >= PERIOD_MIN_US) && (in_period <= PERIOD_MAX_US);

  scs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (in_period[PERIOD_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = per_ok_in ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    apply     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid && per_ok_in;
      end
      ST_DIV: begin
      end
      ST_DONE: begin
        apply = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_tuser;
      period_r <= in_period[PERIOD_W-1:0];
      evt_r    <= in_evt;
      rec_r    <= in_rec;
      batt_r   <= in_batt;
      per_ok_r <= per_ok_in;
    end
  end

  // Event effect, applied when the result is loaded.
  always_comb begin
    started_nxt    = started_r;
    launched_nxt   = launched_r;
    pending_nxt    = pending_r;
    blocked_nxt    = blocked_r;
    start_time_nxt = start_time_r;
    best_rpm_nxt   = best_rpm_r;
    pw             = 1'b0;
    pp             = '0;
    cm             = 1'b0;
    crpm           = '0;
    elapsed        = evt_r - start_time_r;

    case (cmd_r)
      CMD_PERIOD: begin
        if (per_ok_r) begin
          if (div_quo > best_rpm_r) begin
            best_rpm_nxt = div_quo;
          end
          if (!started_r) begin
            start_time_nxt = evt_r;
            started_nxt    = 1'b1;
          end
          if (rec_r) begin
            pw = 1'b1;
            pp = period_r;
          end
        end
      end
      CMD_LAUNCH: begin
        if (!blocked_r && !pending_r) begin
          launched_nxt = 1'b1;
        end
      end
      CMD_FINISH, CMD_ABORT, CMD_TICK: begin
        if ((cmd_r == CMD_FINISH) && !blocked_r && launched_r && started_r &&
            (best_rpm_r != '0)) begin
          pending_nxt = 1'b1;
        end else if ((cmd_r != CMD_TICK) ||
                     (pending_r && (elapsed >= min_delay_r))) begin
          // Abort, failed finish, or a pending session whose delay is over.
          if (cmd_r == CMD_TICK) begin
            cm   = 1'b1;
            crpm = best_rpm_r;
          end
          started_nxt    = 1'b0;
          launched_nxt   = 1'b0;
          pending_nxt    = 1'b0;
          blocked_nxt    = 1'b1;
          start_time_nxt = '0;
          best_rpm_nxt   = '0;
        end
      end
      CMD_REARM: begin
        started_nxt    = 1'b0;
        launched_nxt   = 1'b0;
        pending_nxt    = 1'b0;
        blocked_nxt    = 1'b0;
        start_time_nxt = '0;
        best_rpm_nxt   = '0;
      end
      default: begin
      end
    endcase

    flags = '0;
    flags[FLAG_ACTIVE_BIT]   = started_nxt && !blocked_nxt;
    flags[FLAG_WARNING_BIT]  = (batt_r <= warn_r);
    flags[FLAG_CRITICAL_BIT] = (batt_r <= crit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      launched_r   <= 1'b0;
      pending_r    <= 1'b0;
      blocked_r    <= 1'b0;
      start_time_r <= '0;
      best_rpm_r   <= '0;
    end else if (apply) begin
      started_r    <= started_nxt;
      launched_r   <= launched_nxt;
      pending_r    <= pending_nxt;
      blocked_r    <= blocked_nxt;
      start_time_r <= start_time_nxt;
      best_rpm_r   <= best_rpm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_data_r <= {5'd0, crpm, cm, pp, pw, best_rpm_nxt, flags};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= MIN_DELAY_RST;
      warn_r      <= WARNING_RST;
      crit_r      <= CRITICAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_DELAY: min_delay_r <= cfg_data;
        CFG_WARNING:   warn_r      <= cfg_data[PCT_W-1:0];
        CFG_CRITICAL:  crit_r      <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/scs_checker.sv */
module scs_checker
  import scs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A held result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Only one event is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an event is still in work");

  // A commit ends the session, so it never comes with a profile write and
  // the session no longer shows as active.
  a_commit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42] |-> !out_tdata[21] && !out_tdata[2])
    else $error("commit beat with profile write or active flag");

  // Without a profile write the period field is zero.
  a_profile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[21] |-> out_tdata[41:22] == '0)
    else $error("profile period set without profile write");

endmodule

bind spin_capture_session_core scs_checker u_scs_checker (.*);

/* sim/spin_session_checker.sv */
`timescale 1ns / 100ps

module spin_session_checker
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data,
  output int unsigned           mismatches,
  output int unsigned           results_owed
);

  typedef struct {
    logic [FLAGS_W-1:0]  flags;
    logic [RPM_W-1:0]    peak;
    logic                prof_wr;
    logic [PERIOD_W-1:0] prof_period;
    logic                commit;
    logic [RPM_W-1:0]    commit_rpm;
  } spin_result_t;

  spin_result_t owed_q[$];
  spin_result_t got;
  spin_result_t want;

  // Session state as the block should hold it.
  logic              sess_started;
  logic              sess_launched;
  logic              sess_pending;
  logic              sess_blocked;
  logic [TIME_W-1:0] sess_start_us;
  logic [RPM_W-1:0]  sess_peak;

  logic [TIME_W-1:0] min_delay_reg;
  logic [PCT_W-1:0]  warning_reg;
  logic [PCT_W-1:0]  critical_reg;

  function automatic void clear_session();
    sess_started  = 1'b0;
    sess_launched = 1'b0;
    sess_pending  = 1'b0;
    sess_blocked  = 1'b0;
    sess_start_us = '0;
    sess_peak     = '0;
  endfunction

  function automatic void abort_session();
    clear_session();
    sess_blocked = 1'b1;
  endfunction

  function automatic spin_result_t step_session(input logic [CMD_W-1:0]  cmd,
                                                input logic [TIME_W-1:0] period,
                                                input logic [TIME_W-1:0] evt,
                                                input logic              rec,
                                                input logic [PCT_W-1:0]  batt);
    spin_result_t r;
    logic [TIME_W-1:0] rpm;
    logic [TIME_W-1:0] elapsed;
    r.flags       = '0;
    r.peak        = '0;
    r.prof_wr     = 1'b0;
    r.prof_period = '0;
    r.commit      = 1'b0;
    r.commit_rpm  = '0;
    case (cmd)
      CMD_PERIOD: begin
        if (!sess_blocked && !sess_pending &&
            period >= PERIOD_MIN_US && period <= PERIOD_MAX_US) begin
          rpm = TIME_W'(RPM_NUMERATOR) / period;
          if (rpm > TIME_W'(sess_peak)) sess_peak = rpm[RPM_W-1:0];
          if (!sess_started) begin
            sess_start_us = evt;
            sess_started  = 1'b1;
          end
          if (rec) begin
            r.prof_wr     = 1'b1;
            r.prof_period = period[PERIOD_W-1:0];
          end
        end
      end
      CMD_LAUNCH: begin
        if (!sess_blocked && !sess_pending && !sess_launched) sess_launched = 1'b1;
      end
      CMD_FINISH: begin
        if (!sess_blocked && sess_launched && sess_started && sess_peak != '0)
          sess_pending = 1'b1;
        else
          abort_session();
      end
      CMD_ABORT: abort_session();
      CMD_TICK: begin
        // The elapsed time wraps along with the timestamps.
        elapsed = evt - sess_start_us;
        if (sess_pending && elapsed >= min_delay_reg) begin
          r.commit     = 1'b1;
          r.commit_rpm = sess_peak;
          abort_session();
        end
      end
      CMD_REARM: clear_session();
      default: ;
    endcase
    r.flags[FLAG_ACTIVE_BIT]   = sess_started && !sess_blocked;
    r.flags[FLAG_WARNING_BIT]  = batt <= warning_reg;
    r.flags[FLAG_CRITICAL_BIT] = batt <= critical_reg;
    r.peak = sess_peak;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_session();
      min_delay_reg = MIN_DELAY_RST;
      warning_reg   = WARNING_RST;
      critical_reg  = CRITICAL_RST;
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.flags       = out_tdata[4:0];
        got.peak        = out_tdata[20:5];
        got.prof_wr     = out_tdata[21];
        got.prof_period = out_tdata[41:22];
        got.commit      = out_tdata[42];
        got.commit_rpm  = out_tdata[58:43];
        if (owed_q.size() == 0) begin
          $display("%0t: result beat with no event waiting, expected none, got %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got.flags !== want.flags)
            note_mismatch("flags", want.flags, got.flags);
          if (got.peak !== want.peak)
            note_mismatch("peak_rpm", want.peak, got.peak);
          if (got.prof_wr !== want.prof_wr)
            note_mismatch("profile_write", want.prof_wr, got.prof_wr);
          if (got.prof_period !== want.prof_period)
            note_mismatch("profile_period", want.prof_period, got.prof_period);
          if (got.commit !== want.commit)
            note_mismatch("commit", want.commit, got.commit);
          if (got.commit_rpm !== want.commit_rpm)
            note_mismatch("commit_rpm", want.commit_rpm, got.commit_rpm);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_DELAY: min_delay_reg = cfg_data;
          CFG_WARNING:   warning_reg   = cfg_data[PCT_W-1:0];
          CFG_CRITICAL:  critical_reg  = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        owed_q.push_back(step_session(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                      in_tdata[64], in_tdata[72:65]));
    end
    results_owed = owed_q.size();
  end

endmodule

/* sim/tb_spin_capture_session_core.sv */
`timescale 1ns / 100ps

module tb_spin_capture_session_core;
  import scs_pkg::*;

  // Command codes the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int WATCHDOG_CYCLES  = 5000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 64;
  localparam int PHASE_BEATS      = 190;
  localparam int NUM_PHASES       = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TIME_W-1:0]     cfg_data;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;

  // What the stimulus knows of the current settings and timeline.
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] sess_t0;
  logic [TIME_W-1:0] min_delay_now = MIN_DELAY_RST;
  logic [PCT_W-1:0]  warn_now = WARNING_RST;
  logic [PCT_W-1:0]  crit_now = CRITICAL_RST;

  always #10 clk = ~clk;

  spin_capture_session_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  spin_session_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [CMD_W-1:0]  cmd,
                           input logic [TIME_W-1:0] period,
                           input logic [TIME_W-1:0] evt,
                           input logic              rec,
                           input logic [PCT_W-1:0]  batt);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {7'd0, batt, rec, evt, period};
    in_tuser  = cmd;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Lowers the input valid and waits for every owed result to come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_MIN_DELAY: min_delay_now = value;
      CFG_WARNING:   warn_now      = value[PCT_W-1:0];
      CFG_CRITICAL:  crit_now      = value[PCT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [TIME_W-1:0] pick_period();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return PERIOD_MIN_US - 1;
          1: return PERIOD_MIN_US;
          2: return PERIOD_MAX_US;
          default: return PERIOD_MAX_US + 1;
        endcase
      end
      1: return $urandom;
      2, 3: return $urandom_range(2 * PERIOD_MIN_US, PERIOD_MIN_US);
      default: return $urandom_range(PERIOD_MAX_US, PERIOD_MIN_US);
    endcase
  endfunction

  // Half the time the battery level sits right around one of the thresholds.
  function automatic logic [PCT_W-1:0] pick_battery();
    case ($urandom_range(3))
      0: return warn_now + PCT_W'($urandom_range(2)) - 8'd1;
      1: return crit_now + PCT_W'($urandom_range(2)) - 8'd1;
      default: return PCT_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_tick_offset();
    case ($urandom_range(3))
      0: return $urandom;
      1: return '0;
      2: return min_delay_now >> 1;
      default: return min_delay_now - 1;
    endcase
  endfunction

  task automatic advance_time();
    now_us = now_us + $urandom_range(300000, 1000);
  endtask

  task automatic noise_beat();
    logic [TIME_W-1:0] evt;
    evt = ($urandom_range(1) != 0) ? $urandom : now_us;
    send_beat(CMD_W'($urandom_range(7)), pick_period(), evt, 1'($urandom_range(1)),
              pick_battery());
  endtask

  // An optional re-arm and launch, one to six periods, a finish or an abort and
  // ticks up to the commit delay, with the order and the content varied.
  task automatic run_session();
    int                k;
    int                n_periods;
    int                n_ticks;
    bit                launch_early;
    logic [TIME_W-1:0] offset;
    if ($urandom_range(99) < 85)
      send_beat(CMD_REARM, $urandom, now_us, 1'($urandom_range(1)), pick_battery());
    launch_early = 1'($urandom_range(1));
    if (launch_early && $urandom_range(9) != 0)
      send_beat(CMD_LAUNCH, $urandom, now_us, 1'($urandom_range(1)), pick_battery());
    n_periods = $urandom_range(6, 1);
    for (k = 0; k < n_periods; k++) begin
      advance_time();
      if (k == 0) begin
        sess_t0 = now_us;
        send_beat(CMD_PERIOD, $urandom_range(PERIOD_MAX_US, PERIOD_MIN_US), now_us,
                  1'($urandom_range(1)), pick_battery());
        if (!launch_early && $urandom_range(9) != 0)
          send_beat(CMD_LAUNCH, $urandom, now_us, 1'($urandom_range(1)), pick_battery());
      end else begin
        send_beat(CMD_PERIOD, pick_period(), now_us, 1'($urandom_range(1)),
                  pick_battery());
      end
      if ($urandom_range(9) == 0) noise_beat();
    end
    advance_time();
    if ($urandom_range(9) != 0)
      send_beat(CMD_FINISH, $urandom, now_us, 1'($urandom_range(1)), pick_battery());
    else
      send_beat(CMD_ABORT, $urandom, now_us, 1'($urandom_range(1)), pick_battery());
    n_ticks = $urandom_range(3);
    for (k = 0; k < n_ticks; k++)
      send_beat(CMD_TICK, $urandom, sess_t0 + pick_tick_offset(), 1'($urandom_range(1)),
                pick_battery());
    offset = min_delay_now;
    if (offset < 32'hFFFF_FFF0) offset = offset + $urandom_range(3);
    send_beat(CMD_TICK, $urandom, sess_t0 + offset, 1'($urandom_range(1)), pick_battery());
    now_us = sess_t0 + offset;
  endtask

  task automatic run_random(input int beats);
    int unsigned target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      if ($urandom_range(99) < 80) run_session();
      else noise_beat();
    end
  endtask

  task automatic run_directed();
    logic [TIME_W-1:0] t0;
    t0 = 32'hFFFF_FF00;
    // The first accepted period sits just below the wrap of the timestamp.
    send_beat(CMD_PERIOD, PERIOD_MIN_US - 1, t0, 1'b1, 8'd0);
    send_beat(CMD_PERIOD, PERIOD_MIN_US, t0, 1'b1, crit_now);
    send_beat(CMD_PERIOD, PERIOD_MAX_US, t0 + 10, 1'b1, crit_now + 8'd1);
    send_beat(CMD_PERIOD, PERIOD_MAX_US + 1, t0 + 20, 1'b1, warn_now);
    send_beat(CMD_PERIOD, 32'hFFFF_FFFF, t0 + 30, 1'b1, warn_now + 8'd1);
    send_beat(CMD_PERIOD, '0, t0 + 40, 1'b1, 8'd255);
    send_beat(CMD_LAUNCH, $urandom, t0 + 50, 1'b0, pick_battery());
    send_beat(CMD_LAUNCH, $urandom, t0 + 60, 1'b1, pick_battery());
    send_beat(CMD_SPARE_A, $urandom, $urandom, 1'b1, pick_battery());
    send_beat(CMD_SPARE_B, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_FINISH, $urandom, t0 + 70, 1'b0, pick_battery());
    send_beat(CMD_PERIOD, 2 * PERIOD_MIN_US, t0 + 80, 1'b1, pick_battery());
    send_beat(CMD_LAUNCH, $urandom, t0 + 90, 1'b0, pick_battery());
    send_beat(CMD_TICK, $urandom, t0 + MIN_DELAY_RST - 1, 1'b0, pick_battery());
    send_beat(CMD_TICK, $urandom, t0 + MIN_DELAY_RST, 1'b1, pick_battery());
    send_beat(CMD_PERIOD, 5 * PERIOD_MIN_US, $urandom, 1'b1, pick_battery());
    send_beat(CMD_LAUNCH, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_FINISH, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_TICK, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_REARM, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_FINISH, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_REARM, $urandom, $urandom, 1'b1, pick_battery());
    send_beat(CMD_PERIOD, PERIOD_MAX_US, $urandom, 1'b0, pick_battery());
    send_beat(CMD_FINISH, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_REARM, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_LAUNCH, $urandom, $urandom, 1'b0, pick_battery());
    send_beat(CMD_ABORT, $urandom, $urandom, 1'b1, pick_battery());
  endtask

  task automatic apply_phase_config(input int phase);
    drain_results();
    case (phase)
      0: begin
        write_reg(CFG_MIN_DELAY, MIN_DELAY_RST);
        write_reg(CFG_WARNING, WARNING_RST);
        write_reg(CFG_CRITICAL, CRITICAL_RST);
      end
      1: begin
        write_reg(CFG_MIN_DELAY, '0);
        write_reg(CFG_WARNING, '0);
        write_reg(CFG_CRITICAL, '0);
      end
      2: begin
        write_reg(CFG_MIN_DELAY, 32'hFFFF_FFFF);
        write_reg(CFG_WARNING, 32'd255);
        write_reg(CFG_CRITICAL, 32'd255);
      end
      3: begin
        write_reg(CFG_MIN_DELAY, $urandom_range(2000000, 1));
        write_reg(CFG_WARNING, $urandom_range(255));
        write_reg(CFG_CRITICAL, $urandom_range(255));
      end
      4: begin
        write_reg(CFG_MIN_DELAY, 32'd5000);
        write_reg(CFG_WARNING, 32'd50);
        write_reg(CFG_CRITICAL, 32'd30);
      end
      5: begin
        // Critical above warning, so the critical flag may stand alone.
        write_reg(CFG_MIN_DELAY, 32'd1);
        write_reg(CFG_WARNING, 32'd100);
        write_reg(CFG_CRITICAL, 32'd200);
      end
      6: begin
        write_reg(CFG_MIN_DELAY, $urandom);
        write_reg(CFG_WARNING, $urandom_range(255));
        write_reg(CFG_CRITICAL, $urandom_range(255));
      end
      default: begin
        write_reg(CFG_MIN_DELAY, 32'd500000);
        write_reg(CFG_WARNING, 32'd20);
        write_reg(CFG_CRITICAL, 32'd10);
      end
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    now_us    = $urandom;
    sess_t0   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      apply_phase_config(phase);
      @(posedge clk);
      case (phase % 4)
        1: begin
          tx_idle_pct  = 56;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 56;
        end
        3: begin
          tx_idle_pct  = 25;
          rx_stall_pct = 25;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      // The result side holds off while events keep coming, to fill the block.
      if (phase == 2 || phase == 6) hold_req = 1'b1;
      run_random(PHASE_BEATS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* spin_capture_session_core.f */
rtl/scs_pkg.sv
rtl/scs_div.sv
rtl/spin_capture_session_core.sv
rtl/scs_checker.sv
sim/spin_session_checker.sv
sim/tb_spin_capture_session_core.sv
